// ----- hdl/zsbt_pkg.sv -----
// Shared types and constants for the zone start-up block timer.
package zsbt_pkg;

  localparam int unsigned MapW     = 48;
  localparam int unsigned ZoneFldW = 3;
  localparam int unsigned SecW     = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned DurW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned RelW     = 33;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_GREEN = 2'd1,
    CMD_CROSS = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZONE_MAP  = 2'd0,
    REG_SEC_COUNT = 2'd1,
    REG_BLOCK     = 2'd2,
    REG_GRACE     = 2'd3
  } reg_idx_e;

  localparam logic [CountW-1:0] SecCountRst = 5'd16;
  localparam logic [DurW-1:0]   BlockRst    = 16'd30;
  localparam logic [DurW-1:0]   GraceRst    = 16'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_CMP,
    ST_WALK,
    ST_FLUSH
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [RelW-1:0] a;
    logic [RelW-1:0] b;
  } alu_req_t;

endpackage

// ----- hdl/zsbt_if.sv -----
// Item channel interfaces: event input and permission result output.
interface zsbt_in_if
  import zsbt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [SecW-1:0]  section;
  logic [TimeW-1:0] now_time;

  modport source (output valid, cmd, section, now_time, input ready);
  modport sink   (input valid, cmd, section, now_time, output ready);
endinterface

interface zsbt_out_if
  import zsbt_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [SecW-1:0] target_section;
  logic            permit;
  logic            last;

  modport source (output valid, target_section, permit, last, input ready);
  modport sink   (input valid, target_section, permit, last, output ready);
endinterface

// ----- hdl/zone_startup_block_timer.sv -----
// Top level: zone blocking sequencer with zone state and result buffering.
//
//  channel  dir  fields                                   handshake
//  evt_i    in   cmd, section, now_time                   valid/ready
//  res_o    out  target_section, permit, last             valid/ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i          write enable
//
// Crossing and ignored items end in the idle state. A green item on a
// mapped section walks all sections; a tick compares each zone's release
// time and walks the sections of each released zone, one section per cycle
// unless a result must move into a stalled output. One shared adder serves
// all release-time sums and compares. Reset clears all zone state at once.
module zone_startup_block_timer
  import zsbt_pkg::*;
#(
  parameter int unsigned SECTIONS = 16,
  parameter int unsigned ZONES    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [MapW-1:0]     cfg_data_i,
  zsbt_in_if.sink             evt_i,
  zsbt_out_if.source          res_o
);

  localparam int unsigned SW = $clog2(SECTIONS);
  localparam int unsigned ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  // configuration
  logic [MapW-1:0]   zone_map_q;
  logic [CountW-1:0] sec_count_q;
  logic [DurW-1:0]   block_q, grace_q;
  logic              cfg_clr;

  // zone state
  logic [ZONES-1:0]  blocked_q;
  logic [SecW-1:0]   owner_q [ZONES];
  logic [RelW-1:0]   rel_q   [ZONES];
  logic [TimeW-1:0]  last_tick_q, last_tick_d;

  // sequencer
  state_e            state_q, state_d;
  logic [ZW-1:0]     zc_q, zc_d;
  logic [SW-1:0]     sc_q, sc_d;
  logic [SecW-1:0]   excl_q, excl_d;
  logic              permit_q, permit_d;
  logic              is_tick_q, is_tick_d;
  logic [TimeW-1:0]  now_q, now_d;

  // pending result and output register
  logic              pend_v_q, pend_v_d;
  logic [SecW-1:0]   pend_sec_q, pend_sec_d;
  logic              out_v_q, out_v_d;
  logic [SecW-1:0]   out_sec_q, out_sec_d;
  logic              out_perm_q, out_perm_d;
  logic              out_last_q, out_last_d;

  // zone write port
  logic              zwr_en;
  logic [ZW-1:0]     zwr_idx;
  logic              zwr_blocked;
  logic [SecW-1:0]   zwr_owner;
  logic [RelW-1:0]   zwr_rel;

  alu_req_t          alu_req;
  logic [RelW:0]     alu_res;

  logic              accept;
  logic [ZoneFldW-1:0] in_entry, walk_entry;
  logic              in_zone_ok;
  logic [ZW-1:0]     in_zone, zaddr;
  logic              walk_member, walk_last, zone_last;
  logic              out_free, can_push, walk_stall, hit;
  logic              cross_ok;

  zsbt_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // ---------------- decode ----------------
  assign accept   = evt_i.valid && evt_i.ready;
  assign in_entry = zone_map_q[ZoneFldW*evt_i.section +: ZoneFldW];
  assign in_zone_ok = ({1'b0, evt_i.section} < sec_count_q)
                   && ({1'b0, evt_i.section} < CountW'(SECTIONS))
                   && ({1'b0, in_entry} < 4'(ZONES));
  assign in_zone  = ZW'(in_entry);
  assign zaddr    = (state_q == ST_IDLE) ? in_zone : zc_q;

  assign walk_entry  = zone_map_q[ZoneFldW*sc_q +: ZoneFldW];
  assign walk_member = (CountW'(sc_q) < sec_count_q)
                    && (walk_entry == ZoneFldW'(zc_q))
                    && (SecW'(sc_q) != excl_q);
  assign walk_last   = (sc_q == SW'(SECTIONS - 1));
  assign zone_last   = (zc_q == ZW'(ZONES - 1));

  assign out_free   = !out_v_q || res_o.ready;
  assign can_push   = !pend_v_q || out_free;
  assign walk_stall = walk_member && !can_push;
  assign hit        = blocked_q[zc_q] && alu_res[RelW];
  assign cross_ok   = in_zone_ok && blocked_q[zaddr] && (owner_q[zaddr] == evt_i.section);
  assign cfg_clr    = cfg_we_i && ((cfg_idx_i == REG_ZONE_MAP) || (cfg_idx_i == REG_SEC_COUNT));

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (evt_i.cmd == CMD_TICK)) begin
          state_d = ST_TICK_CMP;
        end else if (accept && (evt_i.cmd == CMD_GREEN) && in_zone_ok) begin
          state_d = ST_WALK;
        end
      end
      ST_TICK_CMP: begin
        if (hit) begin
          state_d = ST_WALK;
        end else if (zone_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_WALK: begin
        if (!walk_stall && walk_last) begin
          if (is_tick_q && !zone_last) begin
            state_d = ST_TICK_CMP;
          end else begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- outputs and datapath ----------------
  always_comb begin
    evt_i.ready = (state_q == ST_IDLE);
    alu_req     = '{op: ALU_ADD, a: '0, b: '0};
    zwr_en      = 1'b0;
    zwr_idx     = zaddr;
    zwr_blocked = blocked_q[zaddr];
    zwr_owner   = owner_q[zaddr];
    zwr_rel     = rel_q[zaddr];
    last_tick_d = last_tick_q;
    zc_d        = zc_q;
    sc_d        = sc_q;
    excl_d      = excl_q;
    permit_d    = permit_q;
    is_tick_d   = is_tick_q;
    now_d       = now_q;
    pend_v_d    = pend_v_q;
    pend_sec_d  = pend_sec_q;
    out_v_d     = out_v_q && !res_o.ready;
    out_sec_d   = out_sec_q;
    out_perm_d  = out_perm_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (evt_i.cmd)
            CMD_TICK: begin
              last_tick_d = evt_i.now_time;
              now_d       = evt_i.now_time;
              zc_d        = '0;
              permit_d    = 1'b1;
              is_tick_d   = 1'b1;
            end
            CMD_GREEN: begin
              alu_req = '{op: ALU_ADD, a: RelW'(evt_i.now_time), b: RelW'(block_q)};
              if (in_zone_ok) begin
                zwr_en      = 1'b1;
                zwr_blocked = 1'b1;
                zwr_owner   = evt_i.section;
                zwr_rel     = alu_res[RelW-1:0];
                zc_d        = in_zone;
                excl_d      = evt_i.section;
                sc_d        = '0;
                permit_d    = 1'b0;
                is_tick_d   = 1'b0;
              end
            end
            CMD_CROSS: begin
              alu_req = '{op: ALU_ADD, a: RelW'(last_tick_q), b: RelW'(grace_q)};
              if (cross_ok) begin
                zwr_en  = 1'b1;
                zwr_rel = alu_res[RelW-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_CMP: begin
        // borrow set means release time < now, i.e. now > release
        alu_req = '{op: ALU_SUB, a: rel_q[zc_q], b: RelW'(now_q)};
        if (hit) begin
          excl_d = owner_q[zc_q];
          sc_d   = '0;
        end else if (!zone_last) begin
          zc_d = ZW'(zc_q + 1'b1);
        end
      end
      ST_WALK: begin
        if (!walk_stall) begin
          if (walk_member) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_sec_d  = pend_sec_q;
              out_perm_d = permit_q;
              out_last_d = 1'b0;
            end
            pend_v_d   = 1'b1;
            pend_sec_d = SecW'(sc_q);
          end
          sc_d = SW'(sc_q + 1'b1);
          if (walk_last && is_tick_q) begin
            zwr_en      = 1'b1;
            zwr_idx     = zc_q;
            zwr_blocked = 1'b0;
            zwr_owner   = '0;
            zwr_rel     = '0;
            if (!zone_last) begin
              zc_d = ZW'(zc_q + 1'b1);
            end
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d    = 1'b1;
          out_sec_d  = pend_sec_q;
          out_perm_d = permit_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid          = out_v_q;
  assign res_o.target_section = out_sec_q;
  assign res_o.permit         = out_perm_q;
  assign res_o.last           = out_last_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_map_q  <= '0;
      sec_count_q <= SecCountRst;
      block_q     <= BlockRst;
      grace_q     <= GraceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ZONE_MAP:  zone_map_q  <= cfg_data_i;
        REG_SEC_COUNT: sec_count_q <= cfg_data_i[CountW-1:0];
        REG_BLOCK:     block_q     <= cfg_data_i[DurW-1:0];
        REG_GRACE:     grace_q     <= cfg_data_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_q <= '0;
      for (int z = 0; z < ZONES; z++) begin
        owner_q[z] <= '0;
        rel_q[z]   <= '0;
      end
    end else if (cfg_clr) begin
      blocked_q <= '0;
      for (int z = 0; z < ZONES; z++) begin
        owner_q[z] <= '0;
        rel_q[z]   <= '0;
      end
    end else if (zwr_en) begin
      blocked_q[zwr_idx] <= zwr_blocked;
      owner_q[zwr_idx]   <= zwr_owner;
      rel_q[zwr_idx]     <= zwr_rel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_tick_q <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_tick_q <= last_tick_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zc_q       <= zc_d;
    sc_q       <= sc_d;
    excl_q     <= excl_d;
    permit_q   <= permit_d;
    is_tick_q  <= is_tick_d;
    now_q      <= now_d;
    pend_sec_q <= pend_sec_d;
    out_sec_q  <= out_sec_d;
    out_perm_q <= out_perm_d;
    out_last_q <= out_last_d;
  end

  // ---------------- assertions ----------------
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.ready |-> !pend_v_q)
    else $error("pending result left over while taking a new item");

  a_flush_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH && pend_v_q && out_free) |=> (res_o.valid && res_o.last))
    else $error("final result not marked last");

  a_cfg_clears_zones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_clr |=> (blocked_q == '0))
    else $error("map or count write did not clear zones");

  a_walk_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && walk_stall) |=> ($stable(sc_q) && state_q == ST_WALK))
    else $error("section walk moved while result path was full");

endmodule

// ----- hdl/zsbt_alu.sv -----
// Shared add / compare unit for release-time arithmetic.
module zsbt_alu
  import zsbt_pkg::*;
(
  input  alu_req_t        req_i,
  output logic [RelW:0]   res_o
);

  // On subtract, res_o[RelW] is the borrow: set when a < b.
  always_comb begin
    unique case (req_i.op)
      ALU_ADD: res_o = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: res_o = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: res_o = '0;
    endcase
  end

endmodule

// ----- bench/zsbt_checker.sv -----
// Checker: watches the event and result channels, predicts permission changes, compares.
module zsbt_checker
  import zsbt_pkg::*;
#(
  parameter int unsigned SECTIONS = 16,
  parameter int unsigned ZONES    = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MapW-1:0]    cfg_data_i,
  zsbt_in_if                 evt_i,
  zsbt_out_if                res_i,
  input  logic               wrap_up_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SecW-1:0] target;
    logic            permit;
    logic            last;
  } perm_t;

  perm_t perm_q[$];

  logic [MapW-1:0]   map_r;
  logic [CountW-1:0] count_r;
  logic [DurW-1:0]   block_r;
  logic [DurW-1:0]   grace_r;
  logic              blocked_r [ZONES];
  logic [SecW-1:0]   owner_r   [ZONES];
  logic [RelW-1:0]   release_r [ZONES];
  logic [TimeW-1:0]  tick_r;
  int                fails;
  bit                wrapped;

  task automatic report_error(string msg);
    if (fails < 40) $display("[%0t] ERROR %s", $time, msg);
    fails++;
  endtask

  // ZONES means the section is unused or mapped to no zone
  function automatic int unsigned zone_of(int unsigned s);
    int unsigned used;
    int unsigned z;
    used = (32'(count_r) > SECTIONS) ? SECTIONS : 32'(count_r);
    if (s >= used) return ZONES;
    z = 32'(map_r[ZoneFldW*s +: ZoneFldW]);
    return (z < ZONES) ? z : ZONES;
  endfunction

  task automatic clear_zones();
    for (int unsigned z = 0; z < ZONES; z++) begin
      blocked_r[z] = 1'b0;
      owner_r[z]   = '0;
      release_r[z] = '0;
    end
  endtask

  task automatic push_perm(int unsigned s, logic permit);
    perm_t p;
    p.target = s[SecW-1:0];
    p.permit = permit;
    p.last   = 1'b0;
    perm_q.push_back(p);
  endtask

  task automatic predict_event(cmd_e cmd, logic [SecW-1:0] sec, logic [TimeW-1:0] now);
    int unsigned z;
    int unsigned base;
    perm_t       p;
    base = perm_q.size();
    case (cmd)
      CMD_TICK: begin
        tick_r = now;
        for (z = 0; z < ZONES; z++) begin
          // release only once the tick is strictly past the release time
          if (blocked_r[z] && ({1'b0, now} > release_r[z])) begin
            for (int unsigned s = 0; s < SECTIONS; s++)
              if (zone_of(s) == z && s != 32'(owner_r[z])) push_perm(s, 1'b1);
            blocked_r[z] = 1'b0;
            owner_r[z]   = '0;
            release_r[z] = '0;
          end
        end
      end
      CMD_GREEN: begin
        z = zone_of(32'(sec));
        if (z < ZONES) begin
          blocked_r[z] = 1'b1;
          owner_r[z]   = sec;
          release_r[z] = {1'b0, now} + RelW'(block_r);
          for (int unsigned s = 0; s < SECTIONS; s++)
            if (zone_of(s) == z && s != 32'(sec)) push_perm(s, 1'b0);
        end
      end
      CMD_CROSS: begin
        z = zone_of(32'(sec));
        if (z < ZONES && blocked_r[z] && owner_r[z] == sec)
          release_r[z] = {1'b0, tick_r} + RelW'(grace_r);
      end
      default: ;
    endcase
    if (perm_q.size() > base) begin
      p = perm_q.pop_back();
      p.last = 1'b1;
      perm_q.push_back(p);
    end
  endtask

  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [MapW-1:0] data);
    case (reg_idx_e'(idx))
      REG_ZONE_MAP: begin
        map_r = data;
        clear_zones();
      end
      REG_SEC_COUNT: begin
        count_r = data[CountW-1:0];
        clear_zones();
      end
      REG_BLOCK: block_r = data[DurW-1:0];
      REG_GRACE: grace_r = data[DurW-1:0];
      default: ;
    endcase
  endtask

  task automatic check_result(logic [SecW-1:0] target, logic permit, logic last);
    perm_t want;
    if (perm_q.size() == 0) begin
      report_error($sformatf("unexpected result: section %0d permit %0b last %0b",
                             target, permit, last));
      return;
    end
    want = perm_q.pop_front();
    if (target !== want.target || permit !== want.permit || last !== want.last)
      report_error($sformatf("result mismatch: got section %0d permit %0b last %0b, want %0d %0b %0b",
                             target, permit, last, want.target, want.permit, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_r   = '0;
      count_r = SecCountRst;
      block_r = BlockRst;
      grace_r = GraceRst;
      tick_r  = '0;
      clear_zones();
      perm_q.delete();
      wrapped = 1'b0;
    end else begin
      // a result at this edge always stems from an item accepted earlier
      if (res_i.valid && res_i.ready)
        check_result(res_i.target_section, res_i.permit, res_i.last);
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (evt_i.valid && evt_i.ready)
        predict_event(cmd_e'(evt_i.cmd), evt_i.section, evt_i.now_time);
      if (wrap_up_i && !wrapped) begin
        wrapped = 1'b1;
        if (perm_q.size() != 0)
          report_error($sformatf("%0d results never arrived", perm_q.size()));
      end
    end
    fail_cnt_o <= fails;
    pending_o  <= perm_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the bench: clock, reset, register writes, event stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import zsbt_pkg::*;

  localparam int unsigned SECTIONS    = 16;
  localparam int unsigned ZONES       = 8;
  localparam int          LIMIT       = 1_000_000;
  localparam int          SETTLE      = 300;
  localparam int          HOLD_CYCLES = 400;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [MapW-1:0]    cfg_data;
  logic               wrap_up;
  int                 fail_cnt;
  int                 pending;

  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 stall_rq;
  int                 stall_seen;
  int                 hold_left;
  int                 cycles = 0;

  logic [CountW-1:0]  cur_count;
  logic [DurW-1:0]    cur_block;
  logic [DurW-1:0]    cur_grace;
  logic [TimeW-1:0]   cur_time;
  logic [SecW-1:0]    recent_sec [4];

  zsbt_in_if  evt_if ();
  zsbt_out_if res_if ();

  zone_startup_block_timer #(
    .SECTIONS (SECTIONS),
    .ZONES    (ZONES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  zsbt_checker #(
    .SECTIONS (SECTIONS),
    .ZONES    (ZONES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_i      (res_if),
    .wrap_up_i  (wrap_up),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    stall_seen   = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (stall_rq != stall_seen) begin
        stall_seen = stall_rq;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // all four registers, one per cycle; the enable stays up across them
  task automatic set_regs(logic [MapW-1:0] map, logic [CountW-1:0] count,
                          logic [DurW-1:0] block, logic [DurW-1:0] grace);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_ZONE_MAP;
    cfg_data <= map;
    @(posedge clk_i);
    cfg_idx  <= REG_SEC_COUNT;
    cfg_data <= MapW'(count);
    @(posedge clk_i);
    cfg_idx  <= REG_BLOCK;
    cfg_data <= MapW'(block);
    @(posedge clk_i);
    cfg_idx  <= REG_GRACE;
    cfg_data <= MapW'(grace);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_count = count;
    cur_block = block;
    cur_grace = grace;
  endtask

  task automatic send_evt(cmd_e cmd, logic [SecW-1:0] sec, logic [TimeW-1:0] now);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      evt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    evt_if.valid    <= 1'b1;
    evt_if.cmd      <= cmd;
    evt_if.section  <= sec;
    evt_if.now_time <= now;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
  endtask

  // a tick that releases nothing can still be walking zones after the last result
  task automatic go_idle();
    evt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [MapW-1:0] make_map(bit two_zones);
    logic [MapW-1:0]     m;
    logic [ZoneFldW-1:0] za;
    logic [ZoneFldW-1:0] zb;
    m  = MapW'({$urandom, $urandom});
    za = ZoneFldW'($urandom_range(0, 7));
    zb = ZoneFldW'($urandom_range(0, 7));
    if (two_zones)
      for (int s = 0; s < 16; s++) m[ZoneFldW*s +: ZoneFldW] = $urandom_range(0, 1) ? za : zb;
    return m;
  endfunction

  // mostly green / tick / owner-crossing traffic on a running clock, some noise
  task automatic random_item();
    int unsigned     r;
    int unsigned     span;
    int unsigned     used;
    logic [SecW-1:0] sec;
    used = (32'(cur_count) > SECTIONS) ? SECTIONS : 32'(cur_count);
    span = 32'((cur_block > cur_grace) ? cur_block : cur_grace) / 3 + 3;
    r    = $urandom_range(0, 99);
    if (r < 38) begin
      if ($urandom_range(0, 19) == 0) cur_time = $urandom;
      else cur_time = cur_time + $urandom_range(0, span);
      send_evt(CMD_TICK, SecW'($urandom_range(0, 15)), cur_time);
    end else if (r < 72) begin
      sec = (used == 0) ? SecW'($urandom_range(0, 15)) : SecW'($urandom_range(0, used - 1));
      recent_sec[2'($urandom_range(0, 3))] = sec;
      send_evt(CMD_GREEN, sec, cur_time + $urandom_range(0, 3));
    end else if (r < 90) begin
      sec = ($urandom_range(0, 3) != 0) ? recent_sec[2'($urandom_range(0, 3))]
                                        : SecW'($urandom_range(0, 15));
      send_evt(CMD_CROSS, sec, $urandom);
    end else if (r < 95) begin
      send_evt(CMD_NONE, SecW'($urandom_range(0, 15)), $urandom);
    end else begin
      send_evt($urandom_range(0, 1) ? CMD_GREEN : CMD_CROSS, SecW'($urandom_range(0, 15)),
               $urandom);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_ZONE_MAP;
    cfg_data         = '0;
    wrap_up          = 1'b0;
    evt_if.valid     = 1'b0;
    evt_if.cmd       = CMD_TICK;
    evt_if.section   = '0;
    evt_if.now_time  = '0;
    send_idle_pct    = 20;
    recv_idle_pct    = 65;
    stall_rq         = 0;
    cur_time         = '0;
    for (int i = 0; i < 4; i++) recent_sec[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all sections in zone 0
    set_regs('0, 5'd16, 16'd30, 16'd10);
    send_evt(CMD_TICK, 4'd0, 32'd5);
    send_evt(CMD_GREEN, 4'd0, 32'd10);
    send_evt(CMD_CROSS, 4'd1, 32'd0);     // not the owner
    send_evt(CMD_GREEN, 4'd15, 32'd12);   // green on a blocked zone takes it over
    send_evt(CMD_TICK, 4'd0, 32'd42);     // equal to release time: still blocked
    send_evt(CMD_CROSS, 4'd15, 32'd0);
    send_evt(CMD_TICK, 4'd0, 32'd52);
    send_evt(CMD_TICK, 4'd0, 32'd53);
    send_evt(CMD_CROSS, 4'd15, 32'd0);    // zone already free
    send_evt(CMD_NONE, 4'd7, 32'hA5A5_5A5A);
    go_idle();

    // zones 1, 2 and 6 over five sections; zero block time
    set_regs(48'h0000_0000_E289, 5'd5, 16'd0, 16'hFFFF);
    send_evt(CMD_GREEN, 4'd7, 32'd100);   // section not in use
    send_evt(CMD_GREEN, 4'd0, 32'd100);
    send_evt(CMD_GREEN, 4'd2, 32'd100);   // lone member: blocked, no results
    send_evt(CMD_TICK, 4'd0, 32'd100);
    send_evt(CMD_TICK, 4'd0, 32'd101);
    go_idle();

    // release time past 32 bits; count above the section total
    set_regs({MapW{1'b1}}, 5'd31, 16'hFFFF, 16'hFFFF);
    send_evt(CMD_GREEN, 4'd9, 32'hFFFF_FFFF);
    send_evt(CMD_TICK, 4'd0, 32'hFFFF_FFFF);
    send_evt(CMD_CROSS, 4'd9, 32'd0);
    send_evt(CMD_TICK, 4'd0, 32'd0);
    go_idle();

    // no section in use
    set_regs({MapW{1'b1}}, 5'd0, 16'd0, 16'd0);
    send_evt(CMD_GREEN, 4'd0, 32'd1);
    send_evt(CMD_TICK, 4'd0, 32'h8000_0000);
    go_idle();

    set_regs({MapW{1'b1}}, 5'd2, 16'd0, 16'd0);
    send_evt(CMD_GREEN, 4'd1, 32'd7);
    send_evt(CMD_TICK, 4'd0, 32'd3);
    send_evt(CMD_CROSS, 4'd1, 32'd0);     // grace 0 from the last tick
    send_evt(CMD_TICK, 4'd0, 32'd4);
    go_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 65;
      end else if (ph < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_regs(make_map(1'b0), 5'd16, DurW'($urandom_range(0, 40)),
                    DurW'($urandom_range(0, 20)));
        1: set_regs(make_map(1'b1), CountW'($urandom_range(2, 16)),
                    DurW'($urandom_range(0, 20)), DurW'($urandom_range(0, 20)));
        2: set_regs(make_map(1'b0), CountW'($urandom_range(0, 31)), 16'd0, 16'hFFFF);
        3: set_regs(make_map(1'b0), 5'd16, 16'hFFFF, 16'd0);
        4: set_regs(make_map(1'b1), 5'd16, 16'd10, 16'd5);
        default: set_regs(make_map(1'b0), CountW'($urandom_range(0, 31)),
                          DurW'($urandom_range(0, 65535)), DurW'($urandom_range(0, 65535)));
      endcase
      cur_time = (ph == 3) ? 32'hFFFF_0000 : $urandom;
      if (ph == 4) stall_rq = stall_rq + 1;
      repeat (25) random_item();
      go_idle();
    end

    wrap_up <= 1'b1;
    repeat (3) @(posedge clk_i);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
